### design/lqs_pkg.sv
// ----------------------------------------------------------------------------
// lqs_pkg
// Field widths, command codes and status codes shared by the linear queue.
// ----------------------------------------------------------------------------
package lqs_pkg;

    // field widths
    localparam int CMD_W   = 2;
    localparam int WORD_W  = 32;
    localparam int STAT_W  = 2;
    localparam int FIDX_W  = 4;

    // command codes
    localparam logic [CMD_W-1:0] CMD_ENQUEUE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_DEQUEUE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_FIND    = 2'd2;

    // status codes
    localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL      = 2'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY     = 2'd2;
    localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd3;

    // word returned by a dequeue on an empty queue
    localparam logic [WORD_W-1:0] EMPTY_WORD = {WORD_W{1'b1}};

endpackage

### design/linear_queue_with_search.sv
// Sequence: enqueue, dequeue and the empty or unused cases register their result in
// S_WORK once the output is free; find on a non-empty queue goes on to S_SCAN, which
// reads one slot a cycle from the single-port store until a match or the tail.
// Throughput: one transaction at a time; the next is taken once the result is
// registered, even while that result still waits to be taken.
// Reset: synchronous, active low; head, tail, state and output valid clear; store kept.
// ----------------------------------------------------------------------------
// linear_queue_with_search
// Linear, non-wrapping queue of 32-bit words in a single-port memory, with
// enqueue, dequeue and a head-to-tail search for the first matching word.
// ----------------------------------------------------------------------------
module linear_queue_with_search #(
    parameter int DEPTH = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [lqs_pkg::CMD_W-1:0]    i_command,
    input  logic signed [lqs_pkg::WORD_W-1:0] i_value,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [lqs_pkg::STAT_W-1:0]   o_status,
    output logic signed [lqs_pkg::WORD_W-1:0] o_data_out,
    output logic [lqs_pkg::FIDX_W-1:0]   o_found_index
);
    import lqs_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

    typedef enum logic [1:0] {
        S_IDLE,
        S_WORK,
        S_SCAN
    } t_state;

    t_state              r_state, n_state;
    logic [CW-1:0]       r_head, n_head;
    logic [CW-1:0]       r_tail, n_tail;
    logic [AW-1:0]       r_scan, n_scan;
    logic [CMD_W-1:0]    r_cmd;
    logic [WORD_W-1:0]   r_word;
    logic                r_out_valid;
    logic [STAT_W-1:0]   r_status;
    logic [WORD_W-1:0]   r_data;
    logic [FIDX_W-1:0]   r_index;

    logic [WORD_W-1:0]   mem [DEPTH];
    logic [WORD_W-1:0]   r_rd_data;
    logic                mem_we;
    logic                mem_re;
    logic [AW-1:0]       mem_addr;

    logic                in_fire;
    logic                out_free;
    logic                res_fire;
    logic [STAT_W-1:0]   res_status;
    logic [WORD_W-1:0]   res_data;
    logic [FIDX_W-1:0]   res_index;
    logic                is_empty;
    logic [CW-1:0]       scan_next;
    logic [AW+FIDX_W-1:0] scan_ext;

    assign o_ready       = (r_state == S_IDLE);
    assign in_fire       = i_valid && o_ready;
    assign out_free      = !r_out_valid || i_ready;
    assign is_empty      = (r_head >= r_tail);
    assign scan_next     = CW'(r_scan) + 1'b1;
    assign scan_ext      = (AW + FIDX_W)'(r_scan);

    assign o_valid       = r_out_valid;
    assign o_status      = r_status;
    assign o_data_out    = r_data;
    assign o_found_index = r_index;

    // decode the current transaction and step the scan
    always_comb begin
        n_state    = r_state;
        n_head     = r_head;
        n_tail     = r_tail;
        n_scan     = r_scan;
        mem_we     = 1'b0;
        mem_re     = 1'b0;
        mem_addr   = r_head[AW-1:0];
        res_fire   = 1'b0;
        res_status = ST_OK;
        res_data   = '0;
        res_index  = '0;
        case (r_state)
            S_IDLE: begin
                // start a read at the head for dequeue and find
                if (in_fire) begin
                    mem_re  = 1'b1;
                    n_state = S_WORK;
                end
            end
            S_WORK: begin
                if (r_cmd == CMD_FIND && !is_empty) begin
                    n_scan  = r_head[AW-1:0];
                    n_state = S_SCAN;
                end else if (out_free) begin
                    res_fire = 1'b1;
                    n_state  = S_IDLE;
                    case (r_cmd)
                        CMD_ENQUEUE: begin
                            if (r_tail >= DEPTH_C) begin
                                res_status = ST_FULL;
                            end else begin
                                mem_we   = 1'b1;
                                mem_addr = r_tail[AW-1:0];
                                n_tail   = r_tail + 1'b1;
                            end
                        end
                        CMD_DEQUEUE: begin
                            if (is_empty) begin
                                res_status = ST_EMPTY;
                                res_data   = EMPTY_WORD;
                            end else begin
                                res_data = r_rd_data;
                                n_head   = r_head + 1'b1;
                            end
                        end
                        CMD_FIND: begin
                            res_status = ST_EMPTY;
                        end
                        default: begin
                            res_status = ST_OK;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                // compare the slot just read, then fetch the next one
                if (r_rd_data == r_word) begin
                    if (out_free) begin
                        res_fire  = 1'b1;
                        res_index = scan_ext[FIDX_W-1:0];
                        n_state   = S_IDLE;
                    end
                end else if (scan_next >= r_tail) begin
                    if (out_free) begin
                        res_fire   = 1'b1;
                        res_status = ST_NOT_FOUND;
                        n_state    = S_IDLE;
                    end
                end else begin
                    mem_re   = 1'b1;
                    mem_addr = scan_next[AW-1:0];
                    n_scan   = scan_next[AW-1:0];
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // single-port entry store, registered read
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_addr] <= r_word;
        end else if (mem_re) begin
            r_rd_data <= mem[mem_addr];
        end
    end

    // hold the transaction payload
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_cmd  <= i_command;
            r_word <= i_value;
        end
        r_scan <= n_scan;
    end

    // state, pointers and registered result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_tail      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_tail  <= n_tail;
            if (res_fire) begin
                r_out_valid <= 1'b1;
                r_status    <= res_status;
                r_data      <= res_data;
                r_index     <= res_index;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // head never passes the tail, tail never passes the depth
    a_head_le_tail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_head <= r_tail)
        else $error("head passed tail");

    a_tail_le_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tail <= DEPTH_C)
        else $error("tail passed depth");

    // scan stays inside the live part of the queue
    a_scan_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (CW'(r_scan) >= r_head && CW'(r_scan) < r_tail))
        else $error("scan outside head to tail");

    // a result is only produced while a transaction is in progress
    a_result_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_fire |-> (r_state != S_IDLE))
        else $error("result without transaction");

endmodule
